FILE: hw/rtl/ccld_pkg.sv
// ---------------------------------------------------------------------------
// ccld_pkg - shared types and codes of the cheat code line decoder
// Result kinds, warning codes, line types, pending modes and the request
// records passed from the decode front to the emit back.
// ---------------------------------------------------------------------------
package ccld_pkg;

  localparam logic [3:0] KIND_GAMEID      = 4'd0;
  localparam logic [3:0] KIND_HOOK        = 4'd1;
  localparam logic [3:0] KIND_OR          = 4'd2;
  localparam logic [3:0] KIND_WRITE       = 4'd3;
  localparam logic [3:0] KIND_AND         = 4'd4;
  localparam logic [3:0] KIND_IFEQ        = 4'd5;
  localparam logic [3:0] KIND_IFNE        = 4'd6;
  localparam logic [3:0] KIND_IFGT        = 4'd7;
  localparam logic [3:0] KIND_IFLT        = 4'd8;
  localparam logic [3:0] KIND_IFAND       = 4'd9;
  localparam logic [3:0] KIND_SEED        = 4'd10;
  localparam logic [3:0] KIND_ADD         = 4'd11;
  localparam logic [3:0] KIND_UNSUPPORTED = 4'd12;
  localparam logic [3:0] KIND_SLIDEPARAMS = 4'd13;
  localparam logic [3:0] KIND_SPAN        = 4'd14;
  localparam logic [3:0] KIND_NOTICE      = 4'd15;

  localparam logic [3:0] TYPE_GAMEID    = 4'h0;
  localparam logic [3:0] TYPE_HOOK      = 4'h1;
  localparam logic [3:0] TYPE_OR16      = 4'h2;
  localparam logic [3:0] TYPE_WRITE8    = 4'h3;
  localparam logic [3:0] TYPE_SLIDE     = 4'h4;
  localparam logic [3:0] TYPE_LIST      = 4'h5;
  localparam logic [3:0] TYPE_AND16     = 4'h6;
  localparam logic [3:0] TYPE_IFEQ      = 4'h7;
  localparam logic [3:0] TYPE_WRITE16   = 4'h8;
  localparam logic [3:0] TYPE_SEED      = 4'h9;
  localparam logic [3:0] TYPE_IFNE      = 4'hA;
  localparam logic [3:0] TYPE_IFGT      = 4'hB;
  localparam logic [3:0] TYPE_IFLT      = 4'hC;
  localparam logic [3:0] TYPE_SPECIAL   = 4'hD;
  localparam logic [3:0] TYPE_ADD16     = 4'hE;

  localparam logic [2:0] WARN_NONE        = 3'd0;
  localparam logic [2:0] WARN_EMPTY_LIST  = 3'd1;
  localparam logic [2:0] WARN_UNKNOWN_D   = 3'd2;
  localparam logic [2:0] WARN_OPEN_SLIDE  = 3'd3;
  localparam logic [2:0] WARN_OPEN_LIST   = 3'd4;

  localparam logic [1:0] MODE_NONE  = 2'd0;
  localparam logic [1:0] MODE_SLIDE = 2'd1;
  localparam logic [1:0] MODE_LIST  = 2'd2;

  localparam logic [1:0] WIDTH_NONE = 2'd0;
  localparam logic [1:0] WIDTH_BYTE = 2'd1;
  localparam logic [1:0] WIDTH_HALF = 2'd2;

  localparam logic [31:0] ADDR_MASK = 32'h0FFF_FFFF;
  localparam logic [31:0] HOOK_BASE = 32'h0800_0000;
  localparam logic [31:0] KEY_REG   = 32'h0400_0130;
  localparam logic [31:0] D_SPECIAL = 32'h0000_0020;
  localparam logic [1:0]  LIST_PER_LINE = 2'd3;

  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;

  typedef struct packed {
    logic [3:0]  kind;
    logic [31:0] target_address;
    logic [15:0] op_value;
    logic [1:0]  access_width;
    logic [15:0] repeat_count;
    logic [15:0] value_increment;
    logic [15:0] address_increment;
    logic [15:0] button_mask;
    logic        mask_present;
    logic        unsigned_compare;
    logic [2:0]  warning;
  } res_t;

  typedef struct packed {
    logic        single;
    res_t        res;
    logic [1:0]  list_n;
    logic [31:0] list_addr;
    logic [31:0] word_hi;
    logic [15:0] word_lo;
    logic        span;
    logic [15:0] span_total;
  } job_t;

endpackage

FILE: hw/rtl/ccld_front.sv
// ---------------------------------------------------------------------------
// ccld_front - line decode and pending state
// Classifies each accepted line against the pending slide or list state and
// builds one request that describes every result the line causes.
// ---------------------------------------------------------------------------
module ccld_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept,
  input  logic           func,
  input  logic [31:0]    word_hi,
  input  logic [15:0]    word_lo,
  output logic           job_valid,
  output ccld_pkg::job_t job
);
  import ccld_pkg::*;

  logic [1:0]  pending_mode_r, pending_mode_nxt;
  logic [15:0] values_left_r, values_left_nxt;
  logic [15:0] list_total_r, list_total_nxt;
  logic [31:0] list_address_r, list_address_nxt;
  logic        list_has_cond_r, list_has_cond_nxt;
  logic        prev_cond_r, prev_cond_nxt;

  always_comb begin
    res_t        r;
    logic [3:0]  ty;
    logic [31:0] addr;
    logic [1:0]  n;
    logic        cond;
    r = '0;
    ty = word_hi[31:28];
    addr = word_hi & ADDR_MASK;
    n = 2'd0;
    cond = 1'b0;
    job = '0;
    job_valid = 1'b0;
    pending_mode_nxt = pending_mode_r;
    values_left_nxt = values_left_r;
    list_total_nxt = list_total_r;
    list_address_nxt = list_address_r;
    list_has_cond_nxt = list_has_cond_r;
    prev_cond_nxt = prev_cond_r;
    if (func) begin
      if (pending_mode_r == MODE_SLIDE || pending_mode_r == MODE_LIST) begin
        r.kind = KIND_NOTICE;
        r.warning = (pending_mode_r == MODE_SLIDE) ? WARN_OPEN_SLIDE : WARN_OPEN_LIST;
        job_valid = 1'b1;
      end
      pending_mode_nxt = MODE_NONE;
      values_left_nxt = '0;
      list_total_nxt = '0;
      list_address_nxt = '0;
      list_has_cond_nxt = 1'b0;
      prev_cond_nxt = 1'b0;
    end else if (pending_mode_r == MODE_LIST) begin
      n = (values_left_r >= {14'd0, LIST_PER_LINE}) ? LIST_PER_LINE : values_left_r[1:0];
      job.list_n = n;
      job.list_addr = list_address_r;
      job.word_hi = word_hi;
      job.word_lo = word_lo;
      job_valid = 1'b1;
      values_left_nxt = values_left_r - {14'd0, n};
      list_address_nxt = list_address_r + {29'd0, n, 1'b0};
      if (values_left_nxt == '0) begin
        job.span = list_has_cond_r;
        job.span_total = list_total_r;
        pending_mode_nxt = MODE_NONE;
        list_total_nxt = '0;
        list_address_nxt = '0;
        list_has_cond_nxt = 1'b0;
      end
      prev_cond_nxt = 1'b0;
    end else if (pending_mode_r == MODE_SLIDE) begin
      r.kind = KIND_SLIDEPARAMS;
      r.repeat_count = word_hi[15:0];
      r.value_increment = word_hi[31:16];
      r.address_increment = word_lo;
      job_valid = 1'b1;
      pending_mode_nxt = MODE_NONE;
      prev_cond_nxt = 1'b0;
    end else begin
      pending_mode_nxt = MODE_NONE;
      job_valid = 1'b1;
      r.target_address = addr;
      r.op_value = word_lo;
      r.access_width = WIDTH_HALF;
      case (ty)
        TYPE_GAMEID: begin
          r.kind = KIND_GAMEID;
          r.access_width = WIDTH_NONE;
        end
        TYPE_HOOK: begin
          r.kind = KIND_HOOK;
          r.target_address = HOOK_BASE | addr;
          r.access_width = WIDTH_NONE;
        end
        TYPE_OR16: r.kind = KIND_OR;
        TYPE_WRITE8: begin
          r.kind = KIND_WRITE;
          r.op_value = {8'd0, word_lo[7:0]};
          r.access_width = WIDTH_BYTE;
        end
        TYPE_SLIDE: begin
          r.kind = KIND_WRITE;
          pending_mode_nxt = MODE_SLIDE;
        end
        TYPE_LIST: begin
          if (word_lo == '0) begin
            r.kind = KIND_UNSUPPORTED;
            r.op_value = '0;
            r.warning = WARN_EMPTY_LIST;
          end else begin
            job_valid = 1'b0;
            pending_mode_nxt = MODE_LIST;
            values_left_nxt = word_lo;
            list_total_nxt = word_lo;
            list_address_nxt = addr;
            list_has_cond_nxt = prev_cond_r;
          end
        end
        TYPE_AND16: r.kind = KIND_AND;
        TYPE_IFEQ: begin
          r.kind = KIND_IFEQ;
          cond = 1'b1;
        end
        TYPE_WRITE16: r.kind = KIND_WRITE;
        TYPE_SEED: begin
          r.kind = KIND_SEED;
          r.target_address = word_hi;
          r.access_width = WIDTH_NONE;
        end
        TYPE_IFNE: begin
          r.kind = KIND_IFNE;
          cond = 1'b1;
        end
        TYPE_IFGT: begin
          r.kind = KIND_IFGT;
          r.unsigned_compare = 1'b1;
          cond = 1'b1;
        end
        TYPE_IFLT: begin
          r.kind = KIND_IFLT;
          r.unsigned_compare = 1'b1;
          cond = 1'b1;
        end
        TYPE_SPECIAL: begin
          if (addr == D_SPECIAL) begin
            r.kind = KIND_IFEQ;
            r.target_address = KEY_REG;
            r.op_value = '0;
            r.button_mask = word_lo;
            r.mask_present = 1'b1;
            cond = 1'b1;
          end else begin
            r.kind = KIND_UNSUPPORTED;
            r.warning = WARN_UNKNOWN_D;
          end
        end
        TYPE_ADD16: r.kind = KIND_ADD;
        default: begin
          r.kind = KIND_IFAND;
          cond = 1'b1;
        end
      endcase
      prev_cond_nxt = cond;
    end
    job.single = (n == 2'd0);
    job.res = r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_mode_r <= MODE_NONE;
      values_left_r <= '0;
      list_total_r <= '0;
      list_address_r <= '0;
      list_has_cond_r <= 1'b0;
      prev_cond_r <= 1'b0;
    end else if (accept) begin
      pending_mode_r <= pending_mode_nxt;
      values_left_r <= values_left_nxt;
      list_total_r <= list_total_nxt;
      list_address_r <= list_address_nxt;
      list_has_cond_r <= list_has_cond_nxt;
      prev_cond_r <= prev_cond_nxt;
    end
  end

`ifndef SYNTHESIS
  a_cond_idle: assert property (@(posedge clk) disable iff (!rst_n)
    prev_cond_r |-> pending_mode_r == MODE_NONE)
    else $error("condition flag set while a slide or list is pending");
  a_list_left: assert property (@(posedge clk) disable iff (!rst_n)
    pending_mode_r == MODE_LIST |-> values_left_r != '0)
    else $error("list pending with no values left");
  a_list_span: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !func && pending_mode_r == MODE_LIST) |-> (job_valid && !job.single))
    else $error("list continuation line built no write request");
`endif

endmodule

FILE: hw/rtl/ccld_queue.sv
// ---------------------------------------------------------------------------
// ccld_queue - request queue
// Two-entry queue of decoded line requests between decode and emit.
// ---------------------------------------------------------------------------
module ccld_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ccld_pkg::job_t push_data,
  output logic           full,
  input  logic           pop,
  output logic           q_valid,
  output ccld_pkg::job_t q_data
);
  import ccld_pkg::*;

  job_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QPTR_W:0]   count_r, count_nxt;

  assign full = (count_r == QDEPTH[QPTR_W:0]);
  assign q_valid = (count_r != '0);
  assign q_data = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("request pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> !pop)
    else $error("request popped from an empty queue");
  a_ptr_track: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0) |-> (wr_ptr_r == rd_ptr_r))
    else $error("queue pointers disagree while empty");
`endif

endmodule

FILE: hw/rtl/ccld_back.sv
// ---------------------------------------------------------------------------
// ccld_back - result emit
// Expands each queued request into one to four results, one per cycle while
// the output is ready, through a registered output stage.
// ---------------------------------------------------------------------------
module ccld_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           q_valid,
  input  ccld_pkg::job_t q_data,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output ccld_pkg::res_t out_res,
  output logic           out_last
);
  import ccld_pkg::*;

  logic [1:0]  idx_r;
  logic        out_valid_r;
  res_t        out_res_r;
  logic        out_last_r;
  logic [2:0]  count;
  logic        load;
  logic        is_last;
  logic [15:0] half;
  res_t        cur;

  assign count = q_data.single ? 3'd1 : ({1'b0, q_data.list_n} + {2'd0, q_data.span});
  assign is_last = ({1'b0, idx_r} == count - 3'd1);
  assign load = q_valid && (!out_valid_r || out_ready);
  assign pop = load && is_last;

  always_comb begin
    cur = '0;
    case (idx_r)
      2'd0: half = q_data.word_hi[31:16];
      2'd1: half = q_data.word_hi[15:0];
      default: half = q_data.word_lo;
    endcase
    if (q_data.single) begin
      cur = q_data.res;
    end else if (idx_r < q_data.list_n) begin
      cur.kind = KIND_WRITE;
      cur.target_address = q_data.list_addr + {29'd0, idx_r, 1'b0};
      cur.op_value = {half[7:0], half[15:8]};
      cur.access_width = WIDTH_HALF;
    end else begin
      cur.kind = KIND_SPAN;
      cur.repeat_count = q_data.span_total;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_res_r <= cur;
      out_last_r <= is_last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        idx_r <= is_last ? 2'd0 : idx_r + 2'd1;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_res = out_res_r;
  assign out_last = out_last_r;

`ifndef SYNTHESIS
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> {1'b0, idx_r} < count)
    else $error("result index beyond request result count");
  a_count_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_valid |-> count != 3'd0)
    else $error("queued request holds no result");
  a_idx_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !q_valid |-> idx_r == 2'd0)
    else $error("result index left mid-request with queue empty");
`endif

endmodule

FILE: hw/rtl/cheat_code_line_decoder.sv
// ---------------------------------------------------------------------------
// cheat_code_line_decoder - cheat code line decoder top level
// Decodes cheat lines into operation results through a decode front, a
// request queue and a result emit back end.
//
//   channel | direction | tdata                          | tuser   | tlast
//   in_     | slave     | word_hi, word_lo               | func    | -
//   out_    | master    | address .. warning             | kind    | last
//
// Decode takes one line per cycle while the queue has room.
// Each line yields zero to four results; the emit stage sends one per cycle
// while the output is ready.
// The two-entry request queue lets decode run ahead while results stall.
// rst_n is synchronous: it clears pending state, the queue and the output.
// ---------------------------------------------------------------------------
module cheat_code_line_decoder (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [47:0]  in_tdata,   // word_hi[31:0], word_lo[47:32]
  input  logic         in_tuser,   // func[0]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [119:0] out_tdata,  // target_address[31:0], op_value[47:32],
                                   // access_width[49:48], repeat_count[65:50],
                                   // value_increment[81:66],
                                   // address_increment[97:82],
                                   // button_mask[113:98], mask_present[114],
                                   // unsigned_compare[115], warning[118:116]
  output logic [3:0]   out_tuser,  // kind[3:0]
  output logic         out_tlast
);
  import ccld_pkg::*;

  logic in_accept;
  logic job_valid;
  job_t job;
  logic q_full;
  logic q_valid;
  job_t q_data;
  logic q_pop;
  res_t res;

  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  ccld_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (in_accept),
    .func      (in_tuser),
    .word_hi   (in_tdata[31:0]),
    .word_lo   (in_tdata[47:32]),
    .job_valid (job_valid),
    .job       (job)
  );

  ccld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_accept && job_valid),
    .push_data (job),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  ccld_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .pop       (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res),
    .out_last  (out_tlast)
  );

  assign out_tuser = res.kind;
  assign out_tdata = {1'b0, res.warning, res.unsigned_compare, res.mask_present,
                      res.button_mask, res.address_increment, res.value_increment,
                      res.repeat_count, res.access_width, res.op_value,
                      res.target_address};

endmodule
